// ----- sv/imu_tilt_pkg.sv -----
// imu_tilt_pkg: shared types, constants and tables for the imu tilt / flight phase block
// no dependencies
package imu_tilt_pkg;

  localparam int CordicStepsDef = 16;
  localparam int QuietCountBitsDef = 16;
  localparam int AtanTabLen = 24;

  // register indexes
  localparam logic [2:0] RegBiasX   = 3'd0;
  localparam logic [2:0] RegBiasY   = 3'd1;
  localparam logic [2:0] RegBiasZ   = 3'd2;
  localparam logic [2:0] RegAccThr  = 3'd3;
  localparam logic [2:0] RegRateThr = 3'd4;
  localparam logic [2:0] RegQuiet   = 3'd5;

  // accel offsets in 1/65536 count
  localparam logic signed [32:0] AccOffX = 33'sd13978508;
  localparam logic signed [32:0] AccOffY = -33'sd7031130;
  localparam logic signed [32:0] AccOffZ = -33'sd59904056;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAT,
    ST_SUMSQ,
    ST_SQRT,
    ST_CORDIC,
    ST_ANGLE,
    ST_DONE
  } seq_state_t;

  // atan table in 1/65536 degree
  function automatic logic signed [23:0] atan_entry(input logic [4:0] i);
    logic signed [23:0] v;
    begin
      unique case (i)
        5'd0:  v = 24'sd2949120;
        5'd1:  v = 24'sd1740967;
        5'd2:  v = 24'sd919879;
        5'd3:  v = 24'sd466945;
        5'd4:  v = 24'sd234379;
        5'd5:  v = 24'sd117304;
        5'd6:  v = 24'sd58666;
        5'd7:  v = 24'sd29335;
        5'd8:  v = 24'sd14668;
        5'd9:  v = 24'sd7334;
        5'd10: v = 24'sd3667;
        5'd11: v = 24'sd1833;
        5'd12: v = 24'sd917;
        5'd13: v = 24'sd458;
        5'd14: v = 24'sd229;
        5'd15: v = 24'sd115;
        5'd16: v = 24'sd57;
        5'd17: v = 24'sd29;
        5'd18: v = 24'sd14;
        5'd19: v = 24'sd7;
        5'd20: v = 24'sd4;
        5'd21: v = 24'sd2;
        5'd22: v = 24'sd1;
        default: v = 24'sd0;
      endcase
      return v;
    end
  endfunction

  // calibration matrix, Q2.16
  function automatic logic signed [17:0] cal_coef(input logic [3:0] k);
    logic signed [17:0] v;
    begin
      unique case (k)
        4'd0: v = 18'sd65745;
        4'd1: v = 18'sd83;
        4'd2: v = 18'sd90;
        4'd3: v = 18'sd83;
        4'd4: v = 18'sd65136;
        4'd5: v = -18'sd58;
        4'd6: v = 18'sd90;
        4'd7: v = -18'sd58;
        4'd8: v = 18'sd64074;
        default: v = 18'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- sv/imu_tilt_if.sv -----
// imu_tilt_if: valid/ready channels for samples and results
// depends on nothing
interface imu_sample_if;
  logic valid;
  logic ready;
  logic signed [15:0] raw_accel_x;
  logic signed [15:0] raw_accel_y;
  logic signed [15:0] raw_accel_z;
  logic signed [15:0] raw_rate_x;
  logic signed [15:0] raw_rate_y;
  logic signed [15:0] raw_rate_z;
  modport source (output valid, raw_accel_x, raw_accel_y, raw_accel_z,
                  raw_rate_x, raw_rate_y, raw_rate_z, input ready);
  modport sink (input valid, raw_accel_x, raw_accel_y, raw_accel_z,
                raw_rate_x, raw_rate_y, raw_rate_z, output ready);
endinterface

interface imu_result_if;
  logic valid;
  logic ready;
  logic signed [16:0] accel_x_cal;
  logic signed [16:0] accel_y_cal;
  logic signed [16:0] accel_z_cal;
  logic signed [16:0] roll_rate;
  logic signed [16:0] pitch_rate;
  logic signed [16:0] yaw_rate;
  logic signed [14:0] pitch_angle;
  logic signed [14:0] roll_angle;
  logic airborne;
  logic landed;
  modport source (output valid, accel_x_cal, accel_y_cal, accel_z_cal, roll_rate,
                  pitch_rate, yaw_rate, pitch_angle, roll_angle, airborne, landed,
                  input ready);
  modport sink (input valid, accel_x_cal, accel_y_cal, accel_z_cal, roll_rate,
                pitch_rate, yaw_rate, pitch_angle, roll_angle, airborne, landed,
                output ready);
endinterface

// ----- sv/imu_tilt_cordic.sv -----
// imu_tilt_cordic: iterative atan2 in vectoring mode, one micro-rotation per cycle
// depends on imu_tilt_pkg
module imu_tilt_cordic
  import imu_tilt_pkg::*;
#(
  parameter int CordicSteps = CordicStepsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [16:0] y_in,
  input  logic [16:0]        x_in,
  output logic               done,
  output logic signed [14:0] angle
);
  localparam int StepBits = $clog2(CordicSteps + 1);

  logic signed [33:0] cx, cy, cx_next, cy_next, sx, sy;
  logic signed [27:0] z, z_next, zr;
  logic [StepBits-1:0] step;
  logic busy, zero_y;
  logic [4:0] idx;

  assign idx = 5'(step);
  assign sx = cx >>> step;
  assign sy = cy >>> step;

  // one micro-rotation
  always_comb begin
    if (cy >= 0) begin
      cx_next = cx + sy;
      cy_next = cy - sx;
      z_next = z + 28'(atan_entry(idx));
    end else begin
      cx_next = cx - sy;
      cy_next = cy + sx;
      z_next = z - 28'(atan_entry(idx));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        cx <= 34'(signed'({1'b0, x_in})) <<< 12;
        cy <= 34'(y_in) <<< 12;
        z <= '0;
        zero_y <= (y_in == 0);
      end else if (busy) begin
        cx <= cx_next;
        cy <= cy_next;
        z <= z_next;
        if (step == StepBits'(CordicSteps - 1) || step == StepBits'(AtanTabLen - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  // round to 1/128 degree and clamp
  assign zr = (z + 28'sd256) >>> 9;
  always_comb begin
    if (zero_y) angle = '0;
    else if (zr > 28'sd11520) angle = 15'sd11520;
    else if (zr < -28'sd11520) angle = -15'sd11520;
    else angle = zr[14:0];
  end
endmodule

// ----- sv/imu_tilt_and_flight_phase_top.sv -----
// imu_tilt_and_flight_phase_top: calibration, tilt and flight phase sequencer
// depends on imu_tilt_pkg, imu_tilt_if, imu_tilt_cordic
//
//  channel | dir | handshake     | payload
//  smp     | in  | valid/ready   | raw accel and gyro counts
//  res     | out | valid/ready   | calibrated values, tilt, phase flags
//  apb     | in  | psel/penable  | six 16-bit config registers
//
// a sample passes through an accept step, 9 matrix products, then per angle 2
// sum-of-squares products, 18 root steps, CordicSteps rotations (capped by the atan
// table length) plus a done strobe and an angle step, then the result hand-off.
// the result is offered once the shared multiplier, the root loop and the rotation
// unit have run for both angles.
// reset clears registers to defaults and the phase flags. a stalled result holds
// the block; the next sample can be taken the cycle after the result transfer.
module imu_tilt_and_flight_phase_top
  import imu_tilt_pkg::*;
#(
  parameter int CordicSteps = CordicStepsDef,
  parameter int QuietCountBits = QuietCountBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  imu_sample_if.sink  smp,
  imu_result_if.source res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  // config registers
  logic signed [15:0] bias_x, bias_y, bias_z;
  logic [15:0] acc_thr, rate_thr, quiet_req;
  logic [2:0] reg_idx;
  assign reg_idx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_x <= '0;
      bias_y <= '0;
      bias_z <= '0;
      acc_thr <= 16'd8192;
      rate_thr <= 16'd655;
      quiet_req <= 16'd50;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegBiasX:   bias_x <= pwdata[15:0];
        RegBiasY:   bias_y <= pwdata[15:0];
        RegBiasZ:   bias_z <= pwdata[15:0];
        RegAccThr:  acc_thr <= pwdata[15:0];
        RegRateThr: rate_thr <= pwdata[15:0];
        RegQuiet:   quiet_req <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegBiasX:   prdata = {16'd0, bias_x};
      RegBiasY:   prdata = {16'd0, bias_y};
      RegBiasZ:   prdata = {16'd0, bias_z};
      RegAccThr:  prdata = {16'd0, acc_thr};
      RegRateThr: prdata = {16'd0, rate_thr};
      RegQuiet:   prdata = {16'd0, quiet_req};
      default:    prdata = '0;
    endcase
  end

  seq_state_t state, state_next;
  logic [3:0] cnt;
  logic [4:0] sq_cnt;
  logic pass;  // 0 pitch, 1 roll

  logic signed [32:0] a_off [3];
  logic signed [16:0] cal [3];
  logic signed [16:0] rate [3];
  logic signed [53:0] acc;
  logic [34:0] sumsq;
  logic [34:0] sq_v, sq_res, sq_bit;
  logic signed [16:0] y_sel;
  logic [16:0] root;
  logic cor_start, cor_done;
  logic signed [14:0] cor_angle;
  logic signed [14:0] pitch_a, roll_a;
  logic takeoff_seen, landing_seen;
  logic [QuietCountBits-1:0] quiet_count;
  logic [1:0] row, col;

  // matrix row and column from the product counter
  assign row = (cnt >= 4'd6) ? 2'd2 : ((cnt >= 4'd3) ? 2'd1 : 2'd0);
  assign col = 2'(cnt - 4'(row) * 4'd3);

  // shared multiplier: matrix coefficient times offset accel, or square of cal
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod;
  always_comb begin
    if (state == ST_MAT) begin
      mul_a = a_off[col];
      mul_b = cal_coef(cnt);
    end else begin
      mul_a = 33'(cal[(cnt[0] ^ pass) ? 2'd2 : (pass ? 2'd0 : 2'd1)]);
      mul_b = 18'(cal[(cnt[0] ^ pass) ? 2'd2 : (pass ? 2'd0 : 2'd1)]);
    end
    prod = 51'(mul_a) * 51'(mul_b);
  end

  // rounding of a matrix row
  logic signed [53:0] row_sum;
  logic signed [21:0] row_r;
  assign row_sum = acc + 54'(prod) + 54'sd2147483648;
  assign row_r = 22'(row_sum >>> 32);

  // root step
  logic [34:0] trial;
  assign trial = sq_res + sq_bit;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (smp.valid) state_next = ST_MAT;
      ST_MAT:    if (cnt == 4'd8) state_next = ST_SUMSQ;
      ST_SUMSQ:  if (cnt == 4'd1) state_next = ST_SQRT;
      ST_SQRT:   if (sq_cnt == 5'd17) state_next = ST_CORDIC;
      ST_CORDIC: if (cor_done) state_next = ST_ANGLE;
      ST_ANGLE:  state_next = pass ? ST_DONE : ST_SUMSQ;
      ST_DONE:   if (res.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    smp.ready = (state == ST_IDLE);
    res.valid = (state == ST_DONE);
    cor_start = (state == ST_SQRT) && (sq_cnt == 5'd17);
  end

  assign y_sel = pass ? cal[1] : cal[0];
  assign root = (trial <= sq_v) ? 17'((sq_res >> 1) + sq_bit) : 17'(sq_res >> 1);

  // phase flags from calibrated and corrected values
  logic acc_hi, rate_hi, quiet;
  always_comb begin
    acc_hi = 1'b0;
    rate_hi = 1'b0;
    quiet = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if ((cal[i] < 0 ? -18'(cal[i]) : 18'(cal[i])) > 18'(acc_thr)) acc_hi = 1'b1;
      if ((rate[i] < 0 ? -18'(rate[i]) : 18'(rate[i])) > 18'(rate_thr)) rate_hi = 1'b1;
      if (!((cal[i] < 0 ? -18'(cal[i]) : 18'(cal[i])) < 18'(acc_thr)) ||
          !((rate[i] < 0 ? -18'(rate[i]) : 18'(rate[i])) < 18'(rate_thr)))
        quiet = 1'b0;
    end
  end

  logic [QuietCountBits-1:0] qc_next;
  always_comb begin
    if (!quiet) qc_next = '0;
    else if (quiet_count != '1) qc_next = quiet_count + 1'b1;
    else qc_next = quiet_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      sq_cnt <= '0;
      pass <= 1'b0;
      takeoff_seen <= 1'b0;
      landing_seen <= 1'b0;
      quiet_count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          pass <= 1'b0;
          acc <= '0;
          if (smp.valid) begin
            a_off[0] <= (33'(smp.raw_accel_x) <<< 16) - AccOffX;
            a_off[1] <= (33'(smp.raw_accel_y) <<< 16) - AccOffY;
            a_off[2] <= (33'(smp.raw_accel_z) <<< 16) - AccOffZ;
            rate[0] <= 17'(smp.raw_rate_x) - 17'(bias_x);
            rate[1] <= 17'(smp.raw_rate_y) - 17'(bias_y);
            rate[2] <= 17'(smp.raw_rate_z) - 17'(bias_z);
          end
        end
        ST_MAT: begin
          // accumulate one row, round and saturate at its end
          if (col == 2'd2) begin
            acc <= '0;
            if (row_r > 22'sd65535) cal[row] <= 17'sd65535;
            else if (row_r < -22'sd65536) cal[row] <= -17'sd65536;
            else cal[row] <= row_r[16:0];
          end else begin
            acc <= acc + 54'(prod);
          end
          cnt <= (cnt == 4'd8) ? 4'd0 : cnt + 1'b1;
        end
        ST_SUMSQ: begin
          if (cnt == 4'd0) sumsq <= 35'(prod);
          else begin
            sq_v <= sumsq + 35'(prod);
            sq_res <= '0;
            sq_bit <= 35'd1 << 34;
            sq_cnt <= '0;
          end
          cnt <= (cnt == 4'd1) ? 4'd0 : cnt + 1'b1;
        end
        ST_SQRT: begin
          if (trial <= sq_v) begin
            sq_v <= sq_v - trial;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 1'b1;
        end
        ST_CORDIC: ;
        ST_ANGLE: begin
          if (pass) roll_a <= cor_angle;
          else pitch_a <= cor_angle;
          pass <= 1'b1;
          cnt <= '0;
          if (pass) begin
            // flight phase update
            if (!takeoff_seen) begin
              if (acc_hi && rate_hi) takeoff_seen <= 1'b1;
            end else begin
              quiet_count <= qc_next;
              if (32'(qc_next) >= 32'(quiet_req)) landing_seen <= 1'b1;
            end
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  imu_tilt_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .y_in  (y_sel),
    .x_in  (root),
    .done  (cor_done),
    .angle (cor_angle)
  );

  assign res.accel_x_cal = cal[0];
  assign res.accel_y_cal = cal[1];
  assign res.accel_z_cal = cal[2];
  assign res.roll_rate = rate[0];
  assign res.pitch_rate = rate[1];
  assign res.yaw_rate = rate[2];
  assign res.pitch_angle = pitch_a;
  assign res.roll_angle = roll_a;
  assign res.airborne = takeoff_seen;
  assign res.landed = landing_seen;

  // checks
  a_landed_needs_air: assert property (@(posedge clk) disable iff (rst)
    landing_seen |-> takeoff_seen) else $error("landed without takeoff");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !smp.ready) else $error("sample taken while result pending");
  a_air_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(takeoff_seen) |-> takeoff_seen) else $error("takeoff flag cleared");
endmodule
